// ----- design/rbps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and codes for the reorder buffer position smoother.
package rbps_pkg;

    // Buffer geometry and id width
    localparam int BUFFER_DEPTH = 8;
    localparam int ID_BITS      = 32;
    localparam int MAX_DELAY    = BUFFER_DEPTH / 2;
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

    // Snap window: distance 1.0 in Q23.8, squared in Q.16
    localparam int SNAP_LIMIT = 256;
    localparam int SNAP_SQ    = 65536;
    localparam int MAG_W      = 9;
    localparam int SQ_W       = 2 * MAG_W;

    // Configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X           = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y           = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FACING_THRESHOLD = 2'd2;
    localparam logic [CFG_DATA_W-1:0] STEP_X_RESET    = 16'd256;
    localparam logic [CFG_DATA_W-1:0] STEP_Y_RESET    = 16'd256;
    localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 16'd0;

    // Input item kinds
    localparam logic KIND_ARRIVE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    typedef struct packed {
        logic               kind;
        logic        [31:0] target_id;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               facing_right;
        logic               moved;
        logic        [31:0] applied_id;
        logic        [3:0]  held_count;
    } out_item_t;

    // One buffered target
    typedef struct packed {
        logic        [ID_BITS-1:0] id;
        logic signed [31:0]        x;
        logic signed [31:0]        y;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_POP,
        CELL_INSERT
    } cell_op_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t op;
        entry_t   item;
    } cell_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARRIVE,
        ST_INSERT,
        ST_STALE,
        ST_BACKLOG,
        ST_STEP,
        ST_DIFF,
        ST_SNAP,
        ST_FACE,
        ST_DONE
    } state_t;

endpackage

// ----- design/rbps_cell.sv -----
`timescale 1ns / 1ps
// One slot of the sorted target chain: holds an entry, shifts left or right.
module rbps_cell
(
    input  logic               clk,
    input  rbps_pkg::cell_ctrl_t ctrl,
    input  logic               occupied,
    input  rbps_pkg::entry_t   left_entry,
    input  logic               left_after,
    input  rbps_pkg::entry_t   right_entry,
    output rbps_pkg::entry_t   entry,
    output logic               after
);

    rbps_pkg::entry_t entry_reg;
    rbps_pkg::entry_t entry_next;

    // Slot sorts after the new item when empty or holding a larger id
    assign after = !occupied || (entry_reg.id > ctrl.item.id);
    assign entry = entry_reg;

    // Select hold, shift toward the front, or open a gap for the new item
    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            rbps_pkg::CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            rbps_pkg::CELL_POP:
            begin
                entry_next = right_entry;
            end
            rbps_pkg::CELL_INSERT:
            begin
                if (after)
                begin
                    entry_next = left_after ? left_entry : ctrl.item;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- design/reorder_buffer_position_smoother_top.sv -----
`timescale 1ns / 1ps
// Top level: sequencer, position datapath and the chain of buffer cells.
// An arrival passes ARRIVE, then INSERT unless it is dropped, then DONE, which registers the result.
// A tick removes stale or skipped entries from the front of the cell chain, one per cycle,
// then runs step and snap if a target is still held, and the facing update in every case.
// One item is in work at a time; the next is accepted once the result is queued.
// Reset (rst_n low, asynchronous) empties the buffer, sets position 0, facing
// right, last applied id 0, and both steps to 256 with threshold 0.
module reorder_buffer_position_smoother_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  rbps_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output rbps_pkg::out_item_t               out_data,
    input  logic                              cfg_we,
    input  logic [rbps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rbps_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int DEPTH = rbps_pkg::BUFFER_DEPTH;
    localparam int CNT_W = rbps_pkg::CNT_W;
    localparam int IDW   = rbps_pkg::ID_BITS;

    // Move one axis toward its target by at most step
    function automatic logic signed [31:0] step_axis
    (
        input logic signed [31:0] pos,
        input logic signed [31:0] target,
        input logic        [15:0] step
    );
        logic signed [32:0] d;
        logic        [32:0] ad;
        d  = $signed({target[31], target}) - $signed({pos[31], pos});
        ad = d[32] ? 33'(-d) : 33'(d);
        if (ad <= {17'b0, step})
        begin
            return target;
        end
        else if (!d[32])
        begin
            return pos + $signed({16'b0, step});
        end
        else
        begin
            return pos - $signed({16'b0, step});
        end
    endfunction

    rbps_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [IDW-1:0]             applied_reg, applied_next;
    logic signed [31:0]         cur_x_reg, cur_x_next;
    logic signed [31:0]         cur_y_reg, cur_y_next;
    logic signed [31:0]         old_x_reg, old_x_next;
    logic                       facing_reg, facing_next;
    logic                       moved_reg, moved_next;
    rbps_pkg::in_item_t         item_reg, item_next;
    logic [rbps_pkg::MAG_W-1:0] mag_x_reg, mag_x_next;
    logic [rbps_pkg::MAG_W-1:0] mag_y_reg, mag_y_next;
    logic                       near_reg, near_next;
    logic                       out_valid_reg, out_valid_next;
    rbps_pkg::out_item_t        out_data_reg, out_data_next;
    logic [15:0]                step_x_reg, step_y_reg, threshold_reg;

    rbps_pkg::cell_ctrl_t       cell_ctrl;
    rbps_pkg::cell_op_t         cell_op;
    rbps_pkg::entry_t           cell_entry [DEPTH];
    logic                       cell_after [DEPTH];
    rbps_pkg::entry_t           front;
    logic [IDW-1:0]             new_id;

    logic signed [32:0]         rdx, rdy, dx;
    logic [32:0]                abs_rdx, abs_rdy, abs_dx;
    logic                       near_x, near_y;
    logic [rbps_pkg::SQ_W-1:0]  sq_x, sq_y;
    logic [rbps_pkg::SQ_W:0]    sq_sum;

    assign front  = cell_entry[0];
    assign new_id = item_reg.target_id[IDW-1:0];

    // Broadcast control to the chain
    always_comb
    begin
        cell_ctrl.op      = cell_op;
        cell_ctrl.item.id = new_id;
        cell_ctrl.item.x  = item_reg.target_x;
        cell_ctrl.item.y  = item_reg.target_y;
    end

    // Chain of buffer cells, front at cell 0
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        rbps_cell u_cell
        (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .occupied    (count_reg > CNT_W'(g)),
            .left_entry  ((g == 0) ? cell_ctrl.item : cell_entry[(g == 0) ? 0 : g - 1]),
            .left_after  ((g == 0) ? 1'b0 : cell_after[(g == 0) ? 0 : g - 1]),
            .right_entry ((g == DEPTH - 1) ? cell_ctrl.item
                                           : cell_entry[(g == DEPTH - 1) ? g : g + 1]),
            .entry       (cell_entry[g]),
            .after       (cell_after[g])
        );
    end

    // Remaining distance after the step, and horizontal motion of the tick
    assign rdx     = $signed({front.x[31], front.x}) - $signed({cur_x_reg[31], cur_x_reg});
    assign rdy     = $signed({front.y[31], front.y}) - $signed({cur_y_reg[31], cur_y_reg});
    assign dx      = $signed({cur_x_reg[31], cur_x_reg}) - $signed({old_x_reg[31], old_x_reg});
    assign abs_rdx = rdx[32] ? 33'(-rdx) : 33'(rdx);
    assign abs_rdy = rdy[32] ? 33'(-rdy) : 33'(rdy);
    assign abs_dx  = dx[32] ? 33'(-dx) : 33'(dx);
    assign near_x  = abs_rdx <= 33'(rbps_pkg::SNAP_LIMIT);
    assign near_y  = abs_rdy <= 33'(rbps_pkg::SNAP_LIMIT);
    assign sq_x    = rbps_pkg::SQ_W'(mag_x_reg) * rbps_pkg::SQ_W'(mag_x_reg);
    assign sq_y    = rbps_pkg::SQ_W'(mag_y_reg) * rbps_pkg::SQ_W'(mag_y_reg);
    assign sq_sum  = (rbps_pkg::SQ_W + 1)'(sq_x) + (rbps_pkg::SQ_W + 1)'(sq_y);

    assign in_stall  = (state_reg != rbps_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Sequencer: next state, chain control and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        applied_next   = applied_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        old_x_next     = old_x_reg;
        facing_next    = facing_reg;
        moved_next     = moved_reg;
        item_next      = item_reg;
        mag_x_next     = mag_x_reg;
        mag_y_next     = mag_y_reg;
        near_next      = near_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        cell_op        = rbps_pkg::CELL_HOLD;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rbps_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    old_x_next = cur_x_reg;
                    moved_next = 1'b0;
                    state_next = (in_data.kind == rbps_pkg::KIND_TICK) ? rbps_pkg::ST_STALE
                                                                       : rbps_pkg::ST_ARRIVE;
                end
            end
            rbps_pkg::ST_ARRIVE:
            begin
                if (new_id <= applied_reg)
                begin
                    state_next = rbps_pkg::ST_DONE;
                end
                else if (count_reg == CNT_W'(DEPTH))
                begin
                    // full: drop the front unless the new item is older still
                    if (new_id < front.id)
                    begin
                        state_next = rbps_pkg::ST_DONE;
                    end
                    else
                    begin
                        cell_op    = rbps_pkg::CELL_POP;
                        count_next = count_reg - CNT_W'(1);
                        state_next = rbps_pkg::ST_INSERT;
                    end
                end
                else
                begin
                    state_next = rbps_pkg::ST_INSERT;
                end
            end
            rbps_pkg::ST_INSERT:
            begin
                cell_op    = rbps_pkg::CELL_INSERT;
                count_next = count_reg + CNT_W'(1);
                state_next = rbps_pkg::ST_DONE;
            end
            rbps_pkg::ST_STALE:
            begin
                // drop entries already applied, one per cycle
                if (count_reg != '0 && front.id <= applied_reg)
                begin
                    cell_op    = rbps_pkg::CELL_POP;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    state_next = rbps_pkg::ST_BACKLOG;
                end
            end
            rbps_pkg::ST_BACKLOG:
            begin
                // skip the front while the backlog is too long
                if (count_reg > CNT_W'(rbps_pkg::MAX_DELAY))
                begin
                    applied_next = front.id;
                    cell_op      = rbps_pkg::CELL_POP;
                    count_next   = count_reg - CNT_W'(1);
                end
                else if (count_reg != '0)
                begin
                    state_next = rbps_pkg::ST_STEP;
                end
                else
                begin
                    state_next = rbps_pkg::ST_FACE;
                end
            end
            rbps_pkg::ST_STEP:
            begin
                cur_x_next = step_axis(cur_x_reg, front.x, step_x_reg);
                cur_y_next = step_axis(cur_y_reg, front.y, step_y_reg);
                state_next = rbps_pkg::ST_DIFF;
            end
            rbps_pkg::ST_DIFF:
            begin
                near_next  = near_x && near_y;
                mag_x_next = abs_rdx[rbps_pkg::MAG_W-1:0];
                mag_y_next = abs_rdy[rbps_pkg::MAG_W-1:0];
                state_next = rbps_pkg::ST_SNAP;
            end
            rbps_pkg::ST_SNAP:
            begin
                // within distance 1.0: snap and retire the front target
                if (near_reg && sq_sum <= (rbps_pkg::SQ_W + 1)'(rbps_pkg::SNAP_SQ))
                begin
                    cur_x_next   = front.x;
                    cur_y_next   = front.y;
                    applied_next = front.id;
                    cell_op      = rbps_pkg::CELL_POP;
                    count_next   = count_reg - CNT_W'(1);
                end
                state_next = rbps_pkg::ST_FACE;
            end
            rbps_pkg::ST_FACE:
            begin
                if (abs_dx > {17'b0, threshold_reg})
                begin
                    moved_next  = 1'b1;
                    facing_next = !dx[32];
                end
                state_next = rbps_pkg::ST_DONE;
            end
            rbps_pkg::ST_DONE:
            begin
                // queue the result once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.pos_x        = cur_x_reg;
                    out_data_next.pos_y        = cur_y_reg;
                    out_data_next.facing_right = facing_reg;
                    out_data_next.moved        = moved_reg;
                    out_data_next.applied_id   = 32'(applied_reg);
                    out_data_next.held_count   = 4'(count_reg);
                    state_next                 = rbps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rbps_pkg::ST_IDLE;
            end
        endcase
    end

    // State register and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rbps_pkg::ST_IDLE;
            count_reg     <= '0;
            applied_reg   <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            facing_reg    <= 1'b1;
            moved_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            applied_reg   <= applied_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            facing_reg    <= facing_next;
            moved_reg     <= moved_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        old_x_reg    <= old_x_next;
        mag_x_reg    <= mag_x_next;
        mag_y_reg    <= mag_y_next;
        near_reg     <= near_next;
        out_data_reg <= out_data_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_x_reg    <= rbps_pkg::STEP_X_RESET;
            step_y_reg    <= rbps_pkg::STEP_Y_RESET;
            threshold_reg <= rbps_pkg::THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rbps_pkg::REG_STEP_X:           step_x_reg    <= cfg_data;
                rbps_pkg::REG_STEP_Y:           step_y_reg    <= cfg_data;
                rbps_pkg::REG_FACING_THRESHOLD: threshold_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Buffer never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("buffer count above depth");

    // After backlog skipping and snap the buffer is at most half full
    a_backlog_trimmed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rbps_pkg::ST_FACE |-> count_reg <= CNT_W'(rbps_pkg::MAX_DELAY))
        else $error("backlog not trimmed before facing update");

    // Front of the chain stays sorted by id
    a_sorted_front: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(2) |-> cell_entry[0].id <= cell_entry[1].id)
        else $error("buffer front out of id order");

    // Step only runs with a target held
    a_step_has_target: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rbps_pkg::ST_STEP |-> count_reg != '0)
        else $error("step with empty buffer");

    // A result appears only when an item completes
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == rbps_pkg::ST_DONE))
        else $error("result transaction without completed item");

endmodule

// ----- tb/sv/reorder_buffer_position_smoother_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench: directed table, then paced random target traffic checked by a predictor.
module reorder_buffer_position_smoother_top_tb;

    import rbps_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 225;
    localparam int SETTLE      = 20;
    // Unmapped register index: writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predicted block state
    entry_t             held_targets[$];
    logic [31:0]        last_applied_id = '0;
    logic signed [31:0] pos_x_now = '0;
    logic signed [31:0] pos_y_now = '0;
    logic               facing_now = 1'b1;
    logic [15:0]        step_x_cfg = STEP_X_RESET;
    logic [15:0]        step_y_cfg = STEP_Y_RESET;
    logic [15:0]        threshold_cfg = THRESHOLD_RESET;

    out_item_t pending_positions[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        items_to_go = PHASES * PHASE_ITEMS;
    int        burst_left = 0;
    int        stall_mode = 0;
    int        stall_run = 0;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } plan_row_t;

    plan_row_t plan[$];

    reorder_buffer_position_smoother_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // End the run if it hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("reorder_buffer_position_smoother_top regression: fail");
            $finish;
        end
    end

    // Stall the result side in modes of random length: none, light, heavy, periodic
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(20, 200);
        end
        stall_run--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= ($urandom_range(0, 99) < 75);
            default: out_stall <= cycle_count[2];
        endcase
    end

    task automatic report(string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t: mismatch: %s", $time, what);
    endtask

    // Compare each result transaction with the oldest pending prediction
    always @(negedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_positions.size() == 0)
                report("result transaction with nothing pending");
            else
            begin
                want = pending_positions.pop_front();
                if (out_data.pos_x !== want.pos_x)
                    report($sformatf("pos_x got %0d, want %0d",
                                     $signed(out_data.pos_x), $signed(want.pos_x)));
                if (out_data.pos_y !== want.pos_y)
                    report($sformatf("pos_y got %0d, want %0d",
                                     $signed(out_data.pos_y), $signed(want.pos_y)));
                if (out_data.facing_right !== want.facing_right)
                    report($sformatf("facing_right got %b, want %b",
                                     out_data.facing_right, want.facing_right));
                if (out_data.moved !== want.moved)
                    report($sformatf("moved got %b, want %b", out_data.moved, want.moved));
                if (out_data.applied_id !== want.applied_id)
                    report($sformatf("applied_id got %0h, want %0h",
                                     out_data.applied_id, want.applied_id));
                if (out_data.held_count !== want.held_count)
                    report($sformatf("held_count got %0d, want %0d",
                                     out_data.held_count, want.held_count));
            end
        end
    end

    // Move one axis toward its target by at most the step
    function automatic logic signed [31:0] slew(logic signed [31:0] from,
                                                logic signed [31:0] dest,
                                                logic [15:0] step);
        longint d;
        d = longint'(dest) - longint'(from);
        if ((d < 0 ? -d : d) <= longint'(step))
            return dest;
        if (d > 0)
            return 32'(longint'(from) + longint'(step));
        return 32'(longint'(from) - longint'(step));
    endfunction

    // Advance the predicted state by one item and return the position it reports
    function automatic out_item_t predict_position(in_item_t it);
        out_item_t          res;
        entry_t             fresh;
        logic signed [31:0] old_x;
        longint             rdx;
        longint             rdy;
        longint             dx;
        int                 slot;
        bit                 moved;
        moved = 1'b0;
        if (it.kind == KIND_ARRIVE)
        begin
            // Keep newer ids sorted; on overflow drop the oldest unless the new one is older
            if (it.target_id > last_applied_id &&
                !(held_targets.size() >= BUFFER_DEPTH && it.target_id < held_targets[0].id))
            begin
                if (held_targets.size() >= BUFFER_DEPTH)
                    void'(held_targets.pop_front());
                fresh.id = it.target_id;
                fresh.x  = it.target_x;
                fresh.y  = it.target_y;
                slot = held_targets.size();
                while (slot > 0 && held_targets[slot-1].id > it.target_id)
                    slot--;
                if (slot == held_targets.size())
                    held_targets = {held_targets, fresh};
                else
                    held_targets.insert(slot, fresh);
            end
        end
        else
        begin
            old_x = pos_x_now;
            // Drop stale entries, then skip backlog beyond half the depth
            while (held_targets.size() > 0 && held_targets[0].id <= last_applied_id)
                void'(held_targets.pop_front());
            while (held_targets.size() > MAX_DELAY)
            begin
                last_applied_id = held_targets[0].id;
                void'(held_targets.pop_front());
            end
            if (held_targets.size() > 0)
            begin
                pos_x_now = slew(pos_x_now, held_targets[0].x, step_x_cfg);
                pos_y_now = slew(pos_y_now, held_targets[0].y, step_y_cfg);
                rdx = longint'($signed(held_targets[0].x)) - longint'(pos_x_now);
                rdy = longint'($signed(held_targets[0].y)) - longint'(pos_y_now);
                // Snap once within a distance of 1.0
                if (rdx >= -SNAP_LIMIT && rdx <= SNAP_LIMIT &&
                    rdy >= -SNAP_LIMIT && rdy <= SNAP_LIMIT &&
                    rdx * rdx + rdy * rdy <= SNAP_SQ)
                begin
                    pos_x_now = held_targets[0].x;
                    pos_y_now = held_targets[0].y;
                    last_applied_id = held_targets[0].id;
                    void'(held_targets.pop_front());
                end
            end
            dx = longint'(pos_x_now) - longint'(old_x);
            if ((dx < 0 ? -dx : dx) > longint'(threshold_cfg))
            begin
                facing_now = (dx > 0);
                moved = 1'b1;
            end
        end
        res.pos_x        = pos_x_now;
        res.pos_y        = pos_y_now;
        res.facing_right = facing_now;
        res.moved        = moved;
        res.applied_id   = last_applied_id;
        res.held_count   = 4'(held_targets.size());
        return res;
    endfunction

    function automatic in_item_t make_item(logic kind, logic [31:0] id,
                                           logic signed [31:0] x, logic signed [31:0] y);
        in_item_t it;
        it.kind      = kind;
        it.target_id = id;
        it.target_x  = x;
        it.target_y  = y;
        return it;
    endfunction

    // Tick with random don't-care fields
    function automatic in_item_t tick_item();
        return make_item(KIND_TICK, $urandom(), $urandom(), $urandom());
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Target a few steps away from the current position, now and then anywhere
    function automatic logic signed [31:0] near_target(logic signed [31:0] from,
                                                       logic [15:0] step);
        longint spread;
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        spread = 4 * longint'(step) + 300;
        return clamp32(longint'(from) + longint'($urandom_range(0, 32'(2 * spread))) - spread);
    endfunction

    function automatic void add_row(logic kind, logic [31:0] id,
                                    logic signed [31:0] x, logic signed [31:0] y);
        plan_row_t r;
        r.item  = make_item(kind, id, x, y);
        r.typed = 1'b0;
        r.want  = '0;
        plan = {plan, r};
    endfunction

    function automatic void add_checked(logic kind, logic [31:0] id,
                                        logic signed [31:0] x, logic signed [31:0] y,
                                        logic signed [31:0] px, logic signed [31:0] py,
                                        logic face, logic mv, logic [31:0] applied,
                                        logic [3:0] held);
        plan_row_t r;
        r.item  = make_item(kind, id, x, y);
        r.typed = 1'b1;
        r.want  = '{pos_x: px, pos_y: py, facing_right: face, moved: mv,
                    applied_id: applied, held_count: held};
        plan = {plan, r};
    endfunction

    // Offer one transaction, wait for acceptance, record the prediction, then pace
    task automatic push_item(in_item_t it, bit typed, out_item_t want);
        bit        taken;
        out_item_t predicted;
        int        gap;
        in_valid <= 1'b1;
        in_data  <= it;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = (in_stall === 1'b0);
            @(posedge clk);
        end
        predicted = predict_position(it);
        if (typed)
            predicted = want;
        pending_positions = {pending_positions, predicted};
        items_to_go--;
        // Bursts of random length, random gaps between them
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 9) < 2) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send(in_item_t it);
        push_item(it, 1'b0, '0);
    endtask

    // Hold off until every pending result has come back and the block is idle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_positions.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_STEP_X:           step_x_cfg = val;
            REG_STEP_Y:           step_y_cfg = val;
            REG_FACING_THRESHOLD: threshold_cfg = val;
            default: ;
        endcase
    endtask

    // Random traffic: mostly arrival bursts followed by ticks, the rest noise
    task automatic run_phase(int count, bit last);
        int          sent;
        int          n_arr;
        int          n_tick;
        int          k;
        longint      room;
        longint      span;
        logic [31:0] base;
        sent = 0;
        while (sent < count)
        begin
            // Spread fresh ids so that they climb through the whole id range
            room = 64'hFFFF_FFFF - longint'(last_applied_id) - 64;
            span = room / (2 * ((items_to_go > 0 ? items_to_go : 0) / 5 + 1));
            if (span < 1)
                span = 1;
            base = last_applied_id + 1 + 32'($urandom_range(0, 32'(span)));
            if (last && count - sent <= 20)
            begin
                // Close with the top of the id range
                for (k = 0; k < 4; k++)
                    send(make_item(KIND_ARRIVE, 32'hFFFF_FFFC + k,
                                   near_target(pos_x_now, step_x_cfg),
                                   near_target(pos_y_now, step_y_cfg)));
                for (k = 0; k < 6; k++)
                    send(tick_item());
                break;
            end
            else if ($urandom_range(0, 99) < 80)
            begin
                n_arr  = $urandom_range(1, 6);
                n_tick = $urandom_range(1, 8);
                for (k = 0; k < n_arr; k++)
                    send(make_item(KIND_ARRIVE, base + $urandom_range(0, 3),
                                   near_target(pos_x_now, step_x_cfg),
                                   near_target(pos_y_now, step_y_cfg)));
                for (k = 0; k < n_tick; k++)
                    send(tick_item());
                sent += n_arr + n_tick;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: send(tick_item());
                    1: send(make_item(KIND_ARRIVE, $urandom_range(0, last_applied_id),
                                      $urandom(), $urandom()));
                    2: send(make_item(KIND_ARRIVE, base, $urandom(), $urandom()));
                    default: send(make_item(KIND_ARRIVE, '0, $urandom(), $urandom()));
                endcase
                sent++;
            end
        end
    endtask

    initial
    begin
        int phase;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at reset settings: step 256, threshold 0
        // empty tick with extreme field values, id 0 never accepted
        add_checked(KIND_TICK, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                    0, 0, 1'b1, 1'b0, 0, 0);
        add_checked(KIND_ARRIVE, 0, 77, 77, 0, 0, 1'b1, 1'b0, 0, 0);
        // out-of-order and equal ids
        add_checked(KIND_ARRIVE, 5, 100, -100, 0, 0, 1'b1, 1'b0, 0, 1);
        add_checked(KIND_ARRIVE, 3, -200, 50, 0, 0, 1'b1, 1'b0, 0, 2);
        add_checked(KIND_ARRIVE, 5, 300, 0, 0, 0, 1'b1, 1'b0, 0, 3);
        // reach and snap moving left, then step-and-snap moving right
        add_checked(KIND_TICK, 0, 0, 0, -200, 50, 1'b0, 1'b1, 3, 2);
        add_checked(KIND_TICK, 0, 0, 0, 100, -100, 1'b1, 1'b1, 5, 1);
        // stale duplicate discarded, old arrival ignored
        add_checked(KIND_TICK, 0, 0, 0, 100, -100, 1'b1, 1'b0, 5, 0);
        add_checked(KIND_ARRIVE, 4, 1, 1, 100, -100, 1'b1, 1'b0, 5, 0);
        // fill past full: the oldest is dropped
        add_checked(KIND_ARRIVE, 20, 0, 0, 100, -100, 1'b1, 1'b0, 5, 1);
        add_checked(KIND_ARRIVE, 21, 32'sh7FFF_FFFF, 32'sh8000_0000,
                    100, -100, 1'b1, 1'b0, 5, 2);
        add_checked(KIND_ARRIVE, 22, 32'sh8000_0000, 32'sh7FFF_FFFF,
                    100, -100, 1'b1, 1'b0, 5, 3);
        add_checked(KIND_ARRIVE, 23, -1, -1, 100, -100, 1'b1, 1'b0, 5, 4);
        add_checked(KIND_ARRIVE, 24, 0, 0, 100, -100, 1'b1, 1'b0, 5, 5);
        add_checked(KIND_ARRIVE, 25, 556, 356, 100, -100, 1'b1, 1'b0, 5, 6);
        add_checked(KIND_ARRIVE, 26, 600, 300, 100, -100, 1'b1, 1'b0, 5, 7);
        add_checked(KIND_ARRIVE, 27, 2000, -2000, 100, -100, 1'b1, 1'b0, 5, 8);
        add_checked(KIND_ARRIVE, 28, 700, 100, 100, -100, 1'b1, 1'b0, 5, 8);
        // backlog skip, then both axes within 256 but farther than 1.0: no snap
        add_checked(KIND_TICK, 0, 0, 0, 356, 156, 1'b1, 1'b1, 24, 4);
        add_row(KIND_TICK, 0, 0, 0);
        add_row(KIND_TICK, 0, 0, 0);
        add_row(KIND_TICK, 0, 0, 0);

        foreach (plan[i])
            push_item(plan[i].item, plan[i].typed, plan[i].want);

        // Random phases, each under its own register settings
        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase)
                1:
                begin
                    write_reg(REG_STEP_X, 16'hFFFF);
                    write_reg(REG_STEP_Y, 16'hFFFF);
                    write_reg(REG_FACING_THRESHOLD, 16'hFFFF);
                end
                2:
                begin
                    write_reg(REG_STEP_X, 16'h0000);
                    write_reg(REG_STEP_Y, 16'h0000);
                    write_reg(REG_FACING_THRESHOLD, 16'h0000);
                end
                3:
                begin
                    write_reg(REG_STEP_X, 16'd1);
                    write_reg(REG_STEP_Y, 16'd1);
                    write_reg(REG_FACING_THRESHOLD, 16'd0);
                    write_reg(REG_SPARE, 16'($urandom()));
                end
                4:
                begin
                    write_reg(REG_STEP_X, 16'($urandom()));
                    write_reg(REG_STEP_Y, 16'($urandom()));
                    write_reg(REG_FACING_THRESHOLD, 16'($urandom_range(0, 1024)));
                end
                5:
                begin
                    write_reg(REG_STEP_X, 16'd512);
                    write_reg(REG_STEP_Y, 16'd64);
                    write_reg(REG_FACING_THRESHOLD, 16'd300);
                end
                default: ;
            endcase
            cfg_we <= 1'b0;
            @(posedge clk);
            run_phase(PHASE_ITEMS, phase == PHASES - 1);
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("reorder_buffer_position_smoother_top regression: pass");
        else
            $display("reorder_buffer_position_smoother_top regression: fail");
        $finish;
    end

endmodule
